### rtl/pcud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed code unpack and dequantize: shared definitions
// Transfer types, widths, reset values and the code width helper.
// ----------------------------------------------------------------------------
package pcud_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 4;
    localparam int BUF_W       = 15;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] BITS_PER_CODE_RESET = 4'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              restart;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sample;
        logic              last_of_byte;
    } out_item_t;

    // A width of zero acts as one, and anything above eight acts as eight.
    function automatic logic [CNT_W-1:0] code_width(input logic [CFG_W-1:0] bpc);
        logic [CNT_W-1:0] n;
        if (bpc == 4'd0) begin
            n = 4'd1;
        end else if (bpc > 4'd8) begin
            n = 4'd8;
        end else begin
            n = bpc;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### rtl/packed_code_unpack_dequantize.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed code unpack and dequantize
// Unpacks N-bit codes packed MSB first from a byte stream and rebuilds each
// code at the midpoint of its interval as an 8-bit sample.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Carries
// s_        in         s_valid / s_ready    code_byte, restart
// m_        out        m_valid / m_ready    sample, last_of_byte
// cfg_      in         cfg_valid/cfg_ready  bits_per_code (4 bits)
//
// A byte is first loaded into the bit buffer and then yields one sample per
// cycle while the result is not stalled; the back end has a single
// extraction path. The input queue keeps accepting while it has room and the
// back end works. Reset empties the queue, the buffer and the output
// register and sets the code width to 7. A stalled result holds the back end.
// ----------------------------------------------------------------------------
module packed_code_unpack_dequantize #(
    parameter int QUEUE_DEPTH = pcud_pkg::QUEUE_DEPTH
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  pcud_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  wire                           m_ready,
    output pcud_pkg::out_item_t           m_item,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [pcud_pkg::CFG_W-1:0]    cfg_data
);
    import pcud_pkg::*;

    logic [CFG_W-1:0] bpc_reg;
    logic             cfg_we;
    logic             q_valid, q_ready;
    in_item_t         q_item;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpc_reg <= BITS_PER_CODE_RESET;
        end else if (cfg_we) begin
            bpc_reg <= cfg_data;
        end
    end

    pcud_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    pcud_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bits_per_code (bpc_reg),
        .cfg_clear     (cfg_we),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item)
    );

endmodule
`default_nettype wire

### rtl/pcud_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed code unpack and dequantize: front end
// Accepts input bytes and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pcud_front #(
    parameter int QUEUE_DEPTH = pcud_pkg::QUEUE_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  pcud_pkg::in_item_t  s_item,
    output logic                q_valid,
    input  wire                 q_ready,
    output pcud_pkg::in_item_t  q_item
);
    import pcud_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    in_item_t        entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            push, pop;

    assign s_ready = (fill_reg != CW'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule
`default_nettype wire

### rtl/pcud_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed code unpack and dequantize: back end
// Holds the bit buffer, extracts one code per cycle while the result is not stalled, and drives the result.
// ----------------------------------------------------------------------------
module pcud_back (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire  [pcud_pkg::CFG_W-1:0]    bits_per_code,
    input  wire                           cfg_clear,
    input  wire                           q_valid,
    output logic                          q_ready,
    input  pcud_pkg::in_item_t            q_item,
    output logic                          m_valid,
    input  wire                           m_ready,
    output pcud_pkg::out_item_t           m_item
);
    import pcud_pkg::*;

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    logic [CNT_W-1:0]  n;
    logic [BUF_W-1:0]  aligned;
    logic [BYTE_W-1:0] window, hi_mask, half;
    logic [BUF_W-1:0]  kept;
    logic              can_emit, room, emit, load;

    assign n        = code_width(bits_per_code);
    assign aligned  = buf_reg << (CNT_W'(BUF_W) - cnt_reg);
    assign window   = aligned[BUF_W-1 -: BYTE_W];
    assign hi_mask  = ~(8'hFF >> n);
    assign half     = 8'h80 >> n;
    assign can_emit = (cnt_reg >= n);
    assign room     = !m_valid_reg || m_ready;
    assign emit     = can_emit && room;
    assign q_ready  = !can_emit && !cfg_clear;
    assign load     = q_valid && q_ready;
    assign kept     = q_item.restart ? '0 : buf_reg;

    always_comb begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_clear) begin
            buf_next = '0;
            cnt_next = '0;
        end else if (load) begin
            buf_next = {kept[BUF_W-BYTE_W-1:0], q_item.code_byte};
            cnt_next = (q_item.restart ? '0 : cnt_reg) + CNT_W'(BYTE_W);
        end else if (emit) begin
            cnt_next                 = cnt_reg - n;
            m_valid_next             = 1'b1;
            m_item_next.sample       = (window & hi_mask) | half;
            m_item_next.last_of_byte = ({1'b0, cnt_reg} < {n, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

### rtl/pcud_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packed code unpack and dequantize: port checker
// Watches the top level ports and checks reset, stall and midpoint behaviour.
// ----------------------------------------------------------------------------
module pcud_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_ready,
    input wire                           m_valid,
    input wire                           m_ready,
    input pcud_pkg::out_item_t           m_item,
    input wire                           cfg_valid,
    input wire                           cfg_ready,
    input wire  [pcud_pkg::CFG_W-1:0]    cfg_data
);
    import pcud_pkg::*;

    logic [CFG_W-1:0]  bpc_reg;
    logic [CNT_W-1:0]  n;
    logic [BYTE_W-1:0] low_mask, half;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpc_reg <= BITS_PER_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bpc_reg <= cfg_data;
        end
    end

    assign n        = code_width(bpc_reg);
    assign low_mask = 8'hFF >> n;
    assign half     = 8'h80 >> n;

    // A result held back by the consumer stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready straight after reset");

    // Every sample sits at the midpoint of its code interval.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.sample & low_mask) == half))
        else $error("sample is not an interval midpoint");

endmodule

bind packed_code_unpack_dequantize pcud_checker u_pcud_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_item    (m_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);
`default_nettype wire

### sim/tb_packed_code_unpack_dequantize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed code unpack and dequantize: self-checking regression bench
// Streams packed code bytes through the block at every code width, including
// widths that are out of range. A model of the bit buffer runs beside the
// block and predicts each reconstructed sample and its end-of-byte flag.
// Both channels idle and stall at random in changing patterns, and the
// results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_packed_code_unpack_dequantize;
    import pcud_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 25;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_item = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    in_item_t          byte_q[$];
    out_item_t         sample_q[$];

    logic [CFG_W-1:0]  model_bpc;
    logic [BUF_W-1:0]  model_buf;
    int                model_cnt;

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                bytes_sent = 0;
    int                samples_checked = 0;
    int                mismatches = 0;
    int                widths_written = 0;

    packed_code_unpack_dequantize i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Appends one byte to the pending bits and queues every sample it completes.
    task automatic unpack_byte(input in_item_t it);
        int        width;
        int        shift;
        int        made;
        int        code;
        int        value;
        out_item_t res;
        width = (model_bpc == 0) ? 1 : (model_bpc > 8) ? 8 : int'(model_bpc);
        if (it.restart) begin
            model_buf = '0;
            model_cnt = 0;
        end
        model_buf = {model_buf[BUF_W-BYTE_W-1:0], it.code_byte};
        model_cnt += BYTE_W;
        made = 0;
        while (model_cnt >= width && made < 8) begin
            shift = model_cnt - width;
            code = int'(model_buf >> shift) & ((1 << width) - 1);
            value = (code << (BYTE_W - width)) + ((1 << (BYTE_W - width)) >> 1);
            model_cnt = shift;
            model_buf = model_buf & ((15'd1 << shift) - 15'd1);
            made++;
            res.sample = value[BYTE_W-1:0];
            res.last_of_byte = !(model_cnt >= width && made < 8);
            sample_q.push_back(res);
        end
    endtask

    task automatic note_mismatch(input string what, input out_item_t exp_r,
                                 input out_item_t got_r);
        if (mismatches < 10) begin
            $display("%t: %s: expected sample %0d last %0b, got sample %0d last %0b",
                     $realtime, what, exp_r.sample, exp_r.last_of_byte,
                     got_r.sample, got_r.last_of_byte);
        end
        mismatches++;
    endtask

    // Input driver: presents queued bytes, idling at random between transfers.
    always @(posedge aclk) begin : drive
        in_item_t nxt_item;
        logic     nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_item = s_item;
            if (s_valid && s_ready) begin
                unpack_byte(s_item);
                bytes_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && byte_q.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                nxt_item = byte_q.pop_front();
                nxt_valid = 1'b1;
            end
            s_valid <= nxt_valid;
            s_item <= nxt_item;
        end
    end

    // Result monitor: checks each transfer against the oldest prediction.
    always @(posedge aclk) begin : watch
        out_item_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    exp_r = '0;
                    note_mismatch("unexpected sample", exp_r, m_item);
                end else begin
                    exp_r = sample_q.pop_front();
                    if (m_item.sample !== exp_r.sample ||
                        m_item.last_of_byte !== exp_r.last_of_byte) begin
                        note_mismatch("sample mismatch", exp_r, m_item);
                    end
                    samples_checked++;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Waits until every queued byte has gone in and every sample has come out.
    task automatic drain(input int extra_cycles);
        while (byte_q.size() != 0 || s_valid || sample_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (extra_cycles) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] bpc);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= bpc;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        model_bpc = bpc;
        model_buf = '0;
        model_cnt = 0;
        widths_written++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic rst);
        in_item_t it;
        it.code_byte = b;
        it.restart = rst;
        byte_q.push_back(it);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] widths[12];
        logic [BYTE_W-1:0] b;
        int               sel;
        widths = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd9,
                   4'd7, 4'd1};
        model_bpc = BITS_PER_CODE_RESET;
        model_buf = '0;
        model_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed bytes at the reset width: extremes, alternating patterns and
        // restarts that discard pending bits.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'hC3, 1'b1);
        drain(SETTLE_CYCLES);

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct = 8;
                    recv_stall_pct = 8;
                end
            endcase
            write_width(widths[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                sel = $urandom_range(0, 7);
                b = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
                push_byte(b, ($urandom_range(0, 9) == 0));
                // Hold the sender back until the block has emptied out.
                if (i == ITEMS_PER_PHASE / 2 && p % 3 == 1) begin
                    drain(0);
                end
            end
            drain(SETTLE_CYCLES);
        end

        $display("Run covered %0d bytes and %0d samples over %0d code width settings,",
                 bytes_sent, samples_checked, widths_written + 1);
        $display("with restarts, out-of-range widths and random idling on both sides.");
        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("packed_code_unpack_dequantize regression: pass");
        end else begin
            $display("packed_code_unpack_dequantize regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timed out with %0d samples outstanding.", sample_q.size());
        $display("packed_code_unpack_dequantize regression: fail");
        $finish;
    end

endmodule
